FILE: rtl/token_stream_parser_top_defines.svh
// Assertion macros for the token stream parser checker
`ifndef TOKEN_STREAM_PARSER_TOP_DEFINES_SVH
`define TOKEN_STREAM_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define TSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tsp_pkg.sv
// Types, constants and helper functions of the token stream parser
`default_nettype none

package tsp_pkg;

    // Longest byte-string or atom length kept, in bits
    localparam int LENGTH_BITS = 24;
    localparam logic [23:0] LEN_MASK = 24'((33'd1 << LENGTH_BITS) - 33'd1);

    // Header byte ranges
    localparam logic [7:0] TINY_SIGNED_MIN = 8'h40;
    localparam logic [7:0] SHORT_MIN       = 8'h80;
    localparam logic [7:0] SHORT_BYTES_MIN = 8'hA0;
    localparam logic [7:0] SHORT_BYTES_MAX = 8'hBF;
    localparam logic [7:0] MEDIUM_MIN      = 8'hC0;
    localparam logic [7:0] MEDIUM_BYTES_MIN = 8'hD0;
    localparam logic [7:0] MEDIUM_BYTES_MAX = 8'hDF;
    localparam logic [7:0] LONG_MIN        = 8'hE0;
    localparam logic [7:0] LONG_BYTES_MIN  = 8'hE2;
    localparam logic [7:0] LONG_BYTES_MAX  = 8'hE3;
    localparam logic [7:0] CONTROL_MIN     = 8'hE4;
    localparam logic [7:0] EMPTY_TOKEN     = 8'hFF;
    localparam logic [7:0] UINT_MIN        = 8'h81;
    localparam logic [7:0] UINT_MAX        = 8'h88;
    localparam logic [7:0] SINT_MIN        = 8'h91;
    localparam logic [7:0] SINT_MAX        = 8'h94;

    // Result kinds
    typedef enum logic [1:0] {
        TK_INTEGER    = 2'd0,
        TK_BYTES_HDR  = 2'd1,
        TK_BYTES_DATA = 2'd2,
        TK_CONTROL    = 2'd3
    } t_token_kind;

    typedef struct packed {
        logic [63:0] value;
        logic        is_signed;
    } t_int_result;

    // Header announces a byte string (short, medium or long)
    function automatic logic header_is_bytes(input logic [7:0] hdr);
        return (hdr >= SHORT_BYTES_MIN && hdr <= SHORT_BYTES_MAX) ||
               (hdr >= MEDIUM_BYTES_MIN && hdr <= MEDIUM_BYTES_MAX) ||
               (hdr >= LONG_BYTES_MIN && hdr <= LONG_BYTES_MAX);
    endfunction

    // Final integer value of a short integer atom (81-88 unsigned, 91-94 signed); else zero
    function automatic t_int_result integer_value(input logic [7:0]  hdr,
                                                  input logic [63:0] acc);
        t_int_result res;
        res.value     = '0;
        res.is_signed = 1'b0;
        if (hdr >= UINT_MIN && hdr <= UINT_MAX) begin
            res.value = acc;
        end else if (hdr >= SINT_MIN && hdr <= SINT_MAX) begin
            res.is_signed = 1'b1;
            case (hdr[2:0])
                3'd1:    res.value = {{56{acc[7]}}, acc[7:0]};
                3'd2:    res.value = {{48{acc[15]}}, acc[15:0]};
                3'd3:    res.value = {{40{acc[23]}}, acc[23:0]};
                default: res.value = {{32{acc[31]}}, acc[31:0]};
            endcase
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/token_stream_parser_top.sv
// Token stream parser: one payload byte per request, atoms and control tokens out
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------
//   in      | input     | i_in_valid / o_in_stall    | i_in_byte, i_in_packet_end
//   out     | output    | o_out_valid / i_out_stall  | kind, header, value, sign, last
//
// One byte per cycle unless the output stalls: an input register feeds the parser
// logic, which updates the parse state and loads the result register in the same cycle.
// A result, if any, is loaded into the result register as its byte leaves the input register.
// Reset (synchronous, active low) returns the parser to awaiting a header.
// o_in_stall rises only while both registers are full and the output is stalled.
`default_nettype none

module token_stream_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_packet_end,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_out_token_kind,
    output logic [7:0]       o_out_header_code,
    output logic [63:0]      o_out_token_value,
    output logic             o_out_is_signed,
    output logic             o_out_data_last
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_INT    = 2'd2,
        PH_DATA   = 2'd3
    } t_phase;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;

    // parse state
    t_phase      r_phase,        n_phase;
    logic [7:0]  r_held_header,  n_held_header;
    logic [23:0] r_bytes_left,   n_bytes_left;
    logic [63:0] r_value_accum,  n_value_accum;
    logic [1:0]  r_len_left,     n_len_left;

    // result register
    logic        r_out_valid;
    tsp_pkg::t_token_kind r_out_kind;
    logic [7:0]  r_out_header;
    logic [63:0] r_out_value;
    logic        r_out_signed;
    logic        r_out_last;

    // result of the current byte
    logic        emit;
    tsp_pkg::t_token_kind e_kind;
    logic [7:0]  e_header;
    logic [63:0] e_value;
    logic        e_signed;
    logic        e_last;

    logic        body_start;
    logic [7:0]  body_hdr;
    logic [23:0] body_len;
    logic [23:0] len_shift;
    logic [23:0] left_dec;
    logic [63:0] accum_shift;
    tsp_pkg::t_int_result int_res;
    logic        advance;

    // the input register moves on unless the result register is held
    assign advance    = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    assign len_shift   = {r_bytes_left[15:0], r_in_byte};
    assign left_dec    = r_bytes_left - 24'd1;
    assign accum_shift = {r_value_accum[55:0], r_in_byte};
    assign int_res     = tsp_pkg::integer_value(r_held_header, accum_shift);

    // parser next state and result
    always_comb begin
        n_phase       = r_phase;
        n_held_header = r_held_header;
        n_bytes_left  = r_bytes_left;
        n_value_accum = r_value_accum;
        n_len_left    = r_len_left;
        emit          = 1'b0;
        e_kind        = tsp_pkg::TK_INTEGER;
        e_header      = r_in_byte;
        e_value       = '0;
        e_signed      = 1'b0;
        e_last        = 1'b0;
        body_start    = 1'b0;
        body_hdr      = r_in_byte;
        body_len      = '0;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_in_byte == tsp_pkg::EMPTY_TOKEN) begin
                    // empty token, skipped
                end else if (r_in_byte < tsp_pkg::TINY_SIGNED_MIN) begin
                    emit    = 1'b1;
                    e_value = {56'd0, r_in_byte};
                end else if (r_in_byte < tsp_pkg::SHORT_MIN) begin
                    emit     = 1'b1;
                    e_value  = {{58{r_in_byte[5]}}, r_in_byte[5:0]};
                    e_signed = 1'b1;
                end else if (r_in_byte < tsp_pkg::MEDIUM_MIN) begin
                    body_start = 1'b1;
                    body_len   = {20'd0, r_in_byte[3:0]};
                end else if (r_in_byte < tsp_pkg::LONG_MIN) begin
                    n_held_header = r_in_byte;
                    n_bytes_left  = {21'd0, r_in_byte[2:0]};
                    n_len_left    = 2'd1;
                    n_phase       = PH_LENGTH;
                end else if (r_in_byte < tsp_pkg::CONTROL_MIN) begin
                    n_held_header = r_in_byte;
                    n_bytes_left  = '0;
                    n_len_left    = 2'd3;
                    n_phase       = PH_LENGTH;
                end else begin
                    emit   = 1'b1;
                    e_kind = tsp_pkg::TK_CONTROL;
                end
            end
            PH_LENGTH: begin
                n_bytes_left = len_shift;
                n_len_left   = r_len_left - 2'd1;
                if (r_len_left == 2'd1) begin
                    body_start = 1'b1;
                    body_hdr   = r_held_header;
                    body_len   = len_shift & tsp_pkg::LEN_MASK;
                end
            end
            PH_INT: begin
                n_value_accum = accum_shift;
                n_bytes_left  = left_dec;
                if (left_dec == '0) begin
                    emit     = 1'b1;
                    e_header = r_held_header;
                    e_value  = int_res.value;
                    e_signed = int_res.is_signed;
                    n_phase  = PH_HEADER;
                end
            end
            PH_DATA: begin
                n_bytes_left = left_dec;
                emit         = 1'b1;
                e_kind       = tsp_pkg::TK_BYTES_DATA;
                e_header     = r_held_header;
                e_value      = {56'd0, r_in_byte};
                e_last       = (left_dec == '0);
                if (left_dec == '0) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        // atom length known: open its body
        if (body_start) begin
            n_held_header = body_hdr;
            n_value_accum = '0;
            n_bytes_left  = body_len;
            if (tsp_pkg::header_is_bytes(body_hdr)) begin
                emit     = 1'b1;
                e_kind   = tsp_pkg::TK_BYTES_HDR;
                e_header = body_hdr;
                e_value  = {40'd0, body_len};
                e_last   = (body_len == '0);
                n_phase  = (body_len != '0) ? PH_DATA : PH_HEADER;
            end else if (body_len != '0) begin
                n_phase = PH_INT;
            end else begin
                // integer atom without content bytes reads as zero
                emit     = 1'b1;
                e_header = body_hdr;
                n_phase  = PH_HEADER;
            end
        end

        // end of packet drops any unfinished atom
        if (r_in_end) begin
            n_phase       = PH_HEADER;
            n_held_header = '0;
            n_bytes_left  = '0;
            n_value_accum = '0;
            n_len_left    = '0;
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_HEADER;
            r_held_header <= '0;
            r_bytes_left  <= '0;
            r_value_accum <= '0;
            r_len_left    <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_phase       <= n_phase;
                r_held_header <= n_held_header;
                r_bytes_left  <= n_bytes_left;
                r_value_accum <= n_value_accum;
                r_len_left    <= n_len_left;
                r_out_valid   <= emit;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_in_packet_end;
        end
        if (advance && emit) begin
            r_out_kind   <= e_kind;
            r_out_header <= e_header;
            r_out_value  <= e_value;
            r_out_signed <= e_signed;
            r_out_last   <= e_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_token_kind  = r_out_kind;
    assign o_out_header_code = r_out_header;
    assign o_out_token_value = r_out_value;
    assign o_out_is_signed   = r_out_signed;
    assign o_out_data_last   = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/tsp_checker.sv
// Port-level checker for the token stream parser, bound to the top level
`default_nettype none

`include "token_stream_parser_top_defines.svh"

module tsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [7:0]  i_in_byte,
    input wire logic        i_in_packet_end,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_out_token_kind,
    input wire logic [7:0]  o_out_header_code,
    input wire logic [63:0] o_out_token_value,
    input wire logic        o_out_is_signed,
    input wire logic        o_out_data_last
);

    // a stalled result stays put
    `TSP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_token_value) && $stable(o_out_header_code), "stalled result changed")

    // the input side stalls only while the output side is stalled
    `TSP_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled without output backpressure")

    // control tokens carry a control byte and no value
    `TSP_ASSERT_NOW(a_control, o_out_valid && o_out_token_kind == tsp_pkg::TK_CONTROL, o_out_header_code >= tsp_pkg::CONTROL_MIN && o_out_header_code != tsp_pkg::EMPTY_TOKEN && o_out_token_value == 64'd0, "bad control token")

    // last flag only on byte-string results, and never signed there
    `TSP_ASSERT_NOW(a_last_kind, o_out_valid && o_out_data_last, (o_out_token_kind == tsp_pkg::TK_BYTES_HDR || o_out_token_kind == tsp_pkg::TK_BYTES_DATA) && !o_out_is_signed, "data_last on non-string result")

endmodule

bind token_stream_parser_top tsp_checker u_tsp_checker (.*);

`default_nettype wire
